// ----- hw/rtl/mmrs_pkg.sv -----
// Shared types and constants for the min-max range scaler.
// Used by mmrs_div, min_max_range_scaler and the testbench; depends on nothing.
`default_nettype none

package mmrs_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	localparam int DATA_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_CW = $clog2(DIV_STEPS + 1);

	localparam logic REG_TARGET_LOW = 1'b0;
	localparam logic REG_TARGET_HIGH = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_MUL,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mmrs_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Requires dividend[31:16] < divisor so the quotient fits in 16 bits.
// Depends on mmrs_pkg.
`default_nettype none

module mmrs_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [mmrs_pkg::PROD_W-1:0]  dividend,
	input  wire logic [mmrs_pkg::DATA_W-1:0]  divisor,
	output mmrs_pkg::div_stat_t               stat,
	output logic      [mmrs_pkg::DATA_W-1:0]  quotient
);

	logic [mmrs_pkg::DATA_W-1:0] rem_q;
	logic [mmrs_pkg::DATA_W-1:0] low_q;
	logic [mmrs_pkg::DATA_W-1:0] dvs_q;
	logic [mmrs_pkg::DIV_CW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [mmrs_pkg::DATA_W:0]   trial;
	logic [mmrs_pkg::DATA_W:0]   diff;
	logic                        qbit;

	assign trial = {rem_q, low_q[mmrs_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= mmrs_pkg::DIV_CW'(mmrs_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - mmrs_pkg::DIV_CW'(1);
			if (cnt_q == mmrs_pkg::DIV_CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[mmrs_pkg::PROD_W-1:mmrs_pkg::DATA_W];
			low_q <= dividend[mmrs_pkg::DATA_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			// shift quotient bits in from the bottom as dividend bits leave the top
			rem_q <= qbit ? diff[mmrs_pkg::DATA_W-1:0] : trial[mmrs_pkg::DATA_W-1:0];
			low_q <= {low_q[mmrs_pkg::DATA_W-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = low_q;

`ifndef ASSERT_OFF
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && !done_q))
		else $error("divider not busy after start");
	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("divider busy and done together");
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("divider done without running");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/min_max_range_scaler.sv -----
// Min-max range scaler. Samples load one per cycle into a 64-entry store while
// the running minimum and maximum are tracked; dropped samples past capacity do
// not count. The item flagged final_req starts the emission of every stored sample
// in load order, rescaled to target_low + (x - min) * (target_high - target_low)
// / (max - min), truncated toward zero and wrapped to 16 bits. Each result passes
// through one store read, one 16x16 multiply, 16 steps of the shared restoring
// divider and one output load, waiting while the output register is held. While
// a set emits, in_ready is low. Write the target registers only while idle.
// Depends on mmrs_pkg and mmrs_div.
`default_nettype none

module min_max_range_scaler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [mmrs_pkg::DATA_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mmrs_pkg::DATA_W-1:0] sample,
	input  wire logic                        final_req,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [mmrs_pkg::DATA_W-1:0] scaled,
	output logic                             end_of_set
);

	mmrs_pkg::state_t            state_q, state_d;
	logic [mmrs_pkg::DATA_W-1:0] tlow_q, thigh_q;
	logic [mmrs_pkg::DATA_W-1:0] min_q, max_q;
	logic [mmrs_pkg::CNT_W-1:0]  fill_q;
	logic [mmrs_pkg::ADDR_W-1:0] idx_q;
	logic [mmrs_pkg::DATA_W-1:0] mem [mmrs_pkg::MAX_SAMPLES];
	logic [mmrs_pkg::DATA_W-1:0] rd_q;
	logic                        out_valid_q, end_q;
	logic [mmrs_pkg::DATA_W-1:0] scaled_q;

	logic                        in_acc, store_en, out_free, is_last;
	logic                        div_start, put, clr;
	logic                        neg, span_zero;
	logic [mmrs_pkg::DATA_W-1:0] span, mag, xdiff, result;
	logic [mmrs_pkg::PROD_W-1:0] prod;
	logic [mmrs_pkg::DATA_W-1:0] quo;
	mmrs_pkg::div_stat_t         div_stat;

	assign in_ready = (state_q == mmrs_pkg::ST_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign store_en = in_acc && (fill_q < mmrs_pkg::CNT_W'(mmrs_pkg::MAX_SAMPLES));
	assign out_free = !out_valid_q || out_ready;
	assign is_last  = (mmrs_pkg::CNT_W'(idx_q) + mmrs_pkg::CNT_W'(1)) == fill_q;

	// signed output span carried as sign and magnitude
	assign neg       = thigh_q < tlow_q;
	assign mag       = neg ? (tlow_q - thigh_q) : (thigh_q - tlow_q);
	assign span      = max_q - min_q;
	assign span_zero = (max_q == min_q);
	assign xdiff     = rd_q - min_q;
	assign prod      = {{mmrs_pkg::DATA_W{1'b0}}, xdiff} * {{mmrs_pkg::DATA_W{1'b0}}, mag};
	assign result    = span_zero ? tlow_q : (neg ? (tlow_q - quo) : (tlow_q + quo));

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		put       = 1'b0;
		clr       = 1'b0;
		unique case (state_q)
			mmrs_pkg::ST_LOAD: begin
				if (in_acc && final_req)
					state_d = mmrs_pkg::ST_READ;
			end
			mmrs_pkg::ST_READ: begin
				state_d = mmrs_pkg::ST_MUL;
			end
			mmrs_pkg::ST_MUL: begin
				div_start = 1'b1;
				state_d   = mmrs_pkg::ST_DIV;
			end
			mmrs_pkg::ST_DIV: begin
				if (div_stat.done && out_free) begin
					put     = 1'b1;
					clr     = is_last;
					state_d = is_last ? mmrs_pkg::ST_LOAD : mmrs_pkg::ST_READ;
				end
			end
			default: state_d = mmrs_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mmrs_pkg::ST_LOAD;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlow_q  <= '0;
			thigh_q <= mmrs_pkg::DATA_W'(4095);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmrs_pkg::REG_TARGET_LOW:  tlow_q  <= cfg_data;
				mmrs_pkg::REG_TARGET_HIGH: thigh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '1;
			max_q  <= '0;
			fill_q <= '0;
			idx_q  <= '0;
		end else if (clr) begin
			min_q  <= '1;
			max_q  <= '0;
			fill_q <= '0;
			idx_q  <= '0;
		end else begin
			if (store_en) begin
				if (sample < min_q)
					min_q <= sample;
				if (sample > max_q)
					max_q <= sample;
				fill_q <= fill_q + mmrs_pkg::CNT_W'(1);
			end
			if (put)
				idx_q <= idx_q + mmrs_pkg::ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (store_en)
			mem[fill_q[mmrs_pkg::ADDR_W-1:0]] <= sample;
		rd_q <= mem[idx_q];
	end

	mmrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (span),
		.stat     (div_stat),
		.quotient (quo)
	);

	// output register: hold the item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (put)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (put) begin
			scaled_q <= result;
			end_q    <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign scaled     = scaled_q;
	assign end_of_set = end_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mmrs_pkg::CNT_W'(mmrs_pkg::MAX_SAMPLES))
		else $error("fill count beyond capacity");
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> (min_q <= max_q))
		else $error("running min above running max");
	a_idx_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mmrs_pkg::ST_LOAD) |-> (mmrs_pkg::CNT_W'(idx_q) < fill_q))
		else $error("emit index past stored samples");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(put && is_last) |=> (fill_q == '0 && out_valid_q && end_q))
		else $error("set not cleared after last item");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_min_max_range_scaler.sv -----
// Self-checking testbench for min_max_range_scaler: directed and random sample sets,
// predicted per accepted item and compared field by field on the result stream.
// Depends on mmrs_pkg and the scaler RTL.
`default_nettype none

module tb_min_max_range_scaler;
	import mmrs_pkg::*;

	localparam int STALL_LEN = 300;
	localparam int SETTLE = 60;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              is_last;
	} scaled_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [DATA_W-1:0] sample = '0;
	logic              final_req = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DATA_W-1:0] scaled;
	logic              end_of_set;

	// Mirror of the block's registers and set state.
	logic [DATA_W-1:0] reg_low = 16'd0;
	logic [DATA_W-1:0] reg_high = 16'd4095;
	logic [DATA_W-1:0] set_store [MAX_SAMPLES];
	logic [DATA_W-1:0] set_min = 16'hFFFF;
	logic [DATA_W-1:0] set_max = 16'h0000;
	int                set_fill = 0;

	scaled_item_t scaled_q [$];
	int           fail_count = 0;
	int           mismatch_count = 0;

	logic idle_en = 1'b1;
	int   stall_tok = 0;
	int   seen_tok = 0;
	int   hold_left = 0;

	min_max_range_scaler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.final_req(final_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scaled(scaled),
		.end_of_set(end_of_set)
	);

	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] rescale(logic [DATA_W-1:0] x);
		longint xl, mn, mx, lo, hi, span, out_span, v;
		xl = x;
		mn = set_min;
		mx = set_max;
		lo = reg_low;
		hi = reg_high;
		span = mx - mn;
		out_span = hi - lo;
		if (span <= 0)
			return reg_low;
		v = ((xl - mn) * out_span) / span + lo;
		return v[DATA_W-1:0];
	endfunction

	task automatic predict_item(input logic [DATA_W-1:0] s, input logic f);
		scaled_item_t item;
		if (set_fill < MAX_SAMPLES) begin
			set_store[set_fill] = s;
			if (s < set_min)
				set_min = s;
			if (s > set_max)
				set_max = s;
			set_fill++;
		end
		if (f) begin
			for (int k = 0; k < set_fill; k++) begin
				item.value = (set_fill == 1) ? reg_low : rescale(set_store[k]);
				item.is_last = (k == set_fill - 1);
				scaled_q.push_back(item);
			end
			set_min = 16'hFFFF;
			set_max = 16'h0000;
			set_fill = 0;
		end
	endtask

	// Called at a rising-edge step; returns at the edge that accepted the item.
	task automatic send_item(input logic [DATA_W-1:0] s, input logic f);
		if (idle_en && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		final_req <= f;
		do
			@(posedge clk);
		while (!in_ready);
		predict_item(s, f);
	endtask

	function automatic logic [DATA_W-1:0] rand_sample(int mode, logic [DATA_W-1:0] base);
		case (mode)
			0: return DATA_W'($urandom);
			1: return base + DATA_W'($urandom_range(0, 15));
			default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	task automatic send_set(input int len, input int mode);
		logic [DATA_W-1:0] base;
		base = DATA_W'($urandom);
		for (int k = 0; k < len; k++)
			send_item(rand_sample(mode, base), k == len - 1);
	endtask

	// Drop valid, wait for every expected item, then let the pipeline settle.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (scaled_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TARGET_LOW)
			reg_low = val;
		else
			reg_high = val;
		@(posedge clk);
	endtask

	task automatic set_targets(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
		wait_drain();
		write_reg(REG_TARGET_LOW, lo);
		write_reg(REG_TARGET_HIGH, hi);
	endtask

	task automatic pick_targets();
		logic [DATA_W-1:0] a;
		a = DATA_W'($urandom);
		case ($urandom_range(0, 5))
			0: set_targets(16'h0000, 16'hFFFF);
			1: set_targets(16'hFFFF, 16'h0000);
			2: set_targets(a, a);
			3: set_targets(a, a + DATA_W'($urandom_range(1, 8)));
			default: set_targets(DATA_W'($urandom), DATA_W'($urandom));
		endcase
	endtask

	task automatic test_reset_targets();
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h8000, 1'b1);
	endtask

	task automatic test_full_range();
		set_targets(16'h0000, 16'hFFFF);
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'hFFFE, 1'b1);
	endtask

	task automatic test_single_sample();
		set_targets(16'h1234, 16'hFFFF);
		send_item(16'h5555, 1'b1);
	endtask

	task automatic test_equal_samples();
		send_item(16'd777, 1'b0);
		send_item(16'd777, 1'b0);
		send_item(16'd777, 1'b1);
	endtask

	task automatic test_inverted_range();
		set_targets(16'hFFFF, 16'h0000);
		send_item(16'd3, 1'b0);
		send_item(16'd1000, 1'b0);
		send_item(16'hFFFF, 1'b1);
		set_targets(16'hFFFF, 16'hFFFF);
		send_item(16'hAAAA, 1'b0);
		send_item(16'h5555, 1'b1);
	endtask

	// Registers written between the loads of one set apply to the whole set.
	task automatic test_config_mid_set();
		set_targets(16'd100, 16'd200);
		send_item(16'd40, 1'b0);
		send_item(16'd9000, 1'b0);
		set_targets(16'd5000, 16'd60000);
		send_item(16'd4500, 1'b1);
	endtask

	task automatic test_store_full();
		set_targets(16'd0, 16'hFFFF);
		send_set(MAX_SAMPLES, 0);
		// Final flag on a dropped sample still emits the stored set.
		send_set(MAX_SAMPLES + 3, 0);
	endtask

	// Hold the receiver off while the first set emits; the two sets behind it wait on in_ready.
	task automatic test_backpressure();
		stall_tok <= stall_tok + 1;
		send_set(10, 0);
		send_set(6, 1);
		send_set(3, 0);
	endtask

	task automatic run_random_sets(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 30)
				pick_targets();
			len = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
			send_set(len, ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 2));
			sent += len;
		end
	endtask

	task automatic test_random_sets();
		run_random_sets(120);
	endtask

	task automatic test_no_idling();
		wait_drain();
		idle_en <= 1'b0;
		run_random_sets(40);
		wait_drain();
		idle_en <= 1'b1;
	endtask

	// Receiver: random stalls while idle_en is set, plus a long counted hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_tok != seen_tok) begin
				seen_tok = stall_tok;
				hold_left = STALL_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (idle_en) begin
				out_ready <= ($urandom_range(99) >= 28);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		scaled_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (scaled_q.size() == 0) begin
				fail_count++;
				if (mismatch_count < 10)
					$display("unexpected item: scaled=%h end_of_set=%b", scaled, end_of_set);
				mismatch_count++;
			end else begin
				want = scaled_q.pop_front();
				if (scaled !== want.value || end_of_set !== want.is_last) begin
					fail_count++;
					if (mismatch_count < 10)
						$display("mismatch: scaled=%h/%h end_of_set=%b/%b (actual/expected)",
							scaled, want.value, end_of_set, want.is_last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_targets();
		test_full_range();
		test_single_sample();
		test_equal_samples();
		test_inverted_range();
		test_config_mid_set();
		test_backpressure();
		test_store_full();
		test_random_sets();
		test_no_idling();
		wait_drain();
		if (scaled_q.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/mmrs_pkg.sv
hw/rtl/mmrs_div.sv
hw/rtl/min_max_range_scaler.sv
dv/tb_min_max_range_scaler.sv
